// ===== rtl/cfpa_pkg.sv =====
// Shared types and codes of the complex fixed-point ALU.
package cfpa_pkg;

  localparam int FIELD_W = 32;

  localparam logic [2:0] MODE_ADD = 3'd0;
  localparam logic [2:0] MODE_SUB = 3'd1;
  localparam logic [2:0] MODE_MUL = 3'd2;
  localparam logic [2:0] MODE_DIV = 3'd3;
  localparam logic [2:0] MODE_NEG = 3'd4;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_SAT  = 2'd1;
  localparam logic [1:0] STATUS_DIV0 = 2'd2;

  typedef struct packed {
    logic neg_re;
    logic neg_im;
    logic div;
    logic dz;
    logic ovf_re;
    logic ovf_im;
  } cfpa_ctl_t;

endpackage

// ===== rtl/cfpa_div_stage.sv =====
// One restoring-division step for both result parts, as a pipeline stage.
module cfpa_div_stage #(
  parameter int DATA_W = 32,
  parameter int REM_W  = 113,
  parameter int BIT    = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  cfpa_pkg::cfpa_ctl_t ctl_i,
  input  logic [2*DATA_W-1:0] den_i,
  input  logic [REM_W-1:0]    r_re_i,
  input  logic [REM_W-1:0]    r_im_i,
  input  logic [DATA_W-1:0]   q_re_i,
  input  logic [DATA_W-1:0]   q_im_i,
  output logic                valid_o,
  input  logic                ready_i,
  output cfpa_pkg::cfpa_ctl_t ctl_o,
  output logic [2*DATA_W-1:0] den_o,
  output logic [REM_W-1:0]    r_re_o,
  output logic [REM_W-1:0]    r_im_o,
  output logic [DATA_W-1:0]   q_re_o,
  output logic [DATA_W-1:0]   q_im_o
);
  import cfpa_pkg::*;

  logic             vld_q;
  logic [REM_W-1:0] dsh;
  logic             take_re;
  logic             take_im;

  assign ready_o = ~vld_q | ready_i;
  assign valid_o = vld_q;
  assign dsh     = REM_W'(den_i) << BIT;
  assign take_re = ctl_i.div && (r_re_i >= dsh);
  assign take_im = ctl_i.div && (r_im_i >= dsh);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      ctl_o  <= ctl_i;
      den_o  <= den_i;
      r_re_o <= take_re ? (r_re_i - dsh) : r_re_i;
      r_im_o <= take_im ? (r_im_i - dsh) : r_im_i;
      q_re_o <= q_re_i | (DATA_W'(take_re) << BIT);
      q_im_o <= q_im_i | (DATA_W'(take_im) << BIT);
    end
  end

endmodule

// ===== rtl/complex_fixed_point_alu_unit.sv =====
// Complex fixed-point ALU: add, subtract, multiply, divide and negate with saturation.
// One request enters per cycle while the output side does not stall; the divider resolves
// one quotient bit per pipeline stage. Operands and results are signed fixed point with
// FRAC_BITS fraction bits in the low DATA_WIDTH bits of each 32-bit field; results are
// sign-extended. Each part is truncated toward zero and saturated; status is 0 ok,
// 1 saturated, 2 division by zero (result zero). Unused modes give zero with status ok.
// Any stage holds its request only while the next one is full and stalled, so bubbles
// close up under back-pressure.
module complex_fixed_point_alu_unit #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // a_re, a_im, b_re, b_im
  input  logic [4*cfpa_pkg::FIELD_W-1:0] s_axis_tdata,
  // mode
  input  logic [2:0]                   s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // res_re, res_im
  output logic [2*cfpa_pkg::FIELD_W-1:0] m_axis_tdata,
  // status
  output logic [1:0]                   m_axis_tuser
);
  import cfpa_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int PW = 2 * W;
  localparam int VW = 2 * W + 1;
  localparam int RW = 3 * W + FRAC_BITS + 1;

  // Input register.
  logic                s0_vld_q, s0_rdy;
  logic [2:0]          s0_mode_q;
  logic signed [W-1:0] s0_ar_q, s0_ai_q, s0_br_q, s0_bi_q;

  // Products and simple sums.
  logic                 s1_vld_q, s1_rdy;
  logic [2:0]           s1_mode_q;
  logic signed [PW-1:0] s1_prr_q, s1_pii_q, s1_pri_q, s1_pir_q, s1_drr_q, s1_dii_q;
  logic signed [W:0]    s1_sre_q, s1_sim_q;
  logic signed [W:0]    s1_sre_d, s1_sim_d;
  logic signed [W:0]    ar_x, ai_x, br_x, bi_x;

  // Signed exact values and divisor.
  logic                 s2_vld_q, s2_rdy;
  logic [2:0]           s2_mode_q;
  logic signed [VW-1:0] s2_vre_q, s2_vim_q, s2_vre_d, s2_vim_d;
  logic [PW-1:0]        s2_den_q, s2_den_d;
  logic                 s2_dz_q;

  // Magnitudes, scaled.
  logic          s3_vld_q, s3_rdy;
  cfpa_ctl_t     s3_ctl_q;
  logic [PW-1:0] s3_den_q;
  logic [RW-1:0] s3_rre_q, s3_rim_q;
  logic [VW-1:0] mag_re, mag_im;
  logic          is_mul, is_div;

  // Quotient overflow check.
  logic          s4_vld_q, s4_rdy;
  cfpa_ctl_t     s4_ctl_q;
  logic [PW-1:0] s4_den_q;
  logic [RW-1:0] s4_rre_q, s4_rim_q;
  logic [RW-1:0] den_top;

  // Division chain.
  logic          dv   [0:W];
  logic          drdy [0:W];
  cfpa_ctl_t     dctl [0:W];
  logic [PW-1:0] dden [0:W];
  logic [RW-1:0] dre  [0:W];
  logic [RW-1:0] dim  [0:W];
  logic [W-1:0]  dqre [0:W];
  logic [W-1:0]  dqim [0:W];

  // Output register.
  logic                 out_vld_q, out_rdy;
  logic [FIELD_W-1:0]   out_re_q, out_im_q;
  logic [1:0]           out_st_q;
  logic [VW-1:0]        fm_re, fm_im;
  logic                 sat_re, sat_im;
  logic [W-1:0]         fv_re, fv_im;
  logic [VW-1:0]        lim_neg, lim_pos;

  assign s_axis_tready = s0_rdy;
  assign s0_rdy  = ~s0_vld_q | s1_rdy;
  assign s1_rdy  = ~s1_vld_q | s2_rdy;
  assign s2_rdy  = ~s2_vld_q | s3_rdy;
  assign s3_rdy  = ~s3_vld_q | s4_rdy;
  assign s4_rdy  = ~s4_vld_q | drdy[0];
  assign out_rdy = ~out_vld_q | m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q  <= 1'b0;
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s0_rdy)  s0_vld_q  <= s_axis_tvalid;
      if (s1_rdy)  s1_vld_q  <= s0_vld_q;
      if (s2_rdy)  s2_vld_q  <= s1_vld_q;
      if (s3_rdy)  s3_vld_q  <= s2_vld_q;
      if (s4_rdy)  s4_vld_q  <= s3_vld_q;
      if (out_rdy) out_vld_q <= dv[W];
    end
  end

  // Stage 0: capture the request.
  always_ff @(posedge clk_i) begin
    if (s0_rdy && s_axis_tvalid) begin
      s0_mode_q <= s_axis_tuser;
      s0_ar_q   <= $signed(s_axis_tdata[0*FIELD_W +: W]);
      s0_ai_q   <= $signed(s_axis_tdata[1*FIELD_W +: W]);
      s0_br_q   <= $signed(s_axis_tdata[2*FIELD_W +: W]);
      s0_bi_q   <= $signed(s_axis_tdata[3*FIELD_W +: W]);
    end
  end

  // Stage 1: the six products and the results of the linear operations.
  assign ar_x = {s0_ar_q[W-1], s0_ar_q};
  assign ai_x = {s0_ai_q[W-1], s0_ai_q};
  assign br_x = {s0_br_q[W-1], s0_br_q};
  assign bi_x = {s0_bi_q[W-1], s0_bi_q};

  always_comb begin
    case (s0_mode_q)
      MODE_ADD: begin
        s1_sre_d = ar_x + br_x;
        s1_sim_d = ai_x + bi_x;
      end
      MODE_SUB: begin
        s1_sre_d = ar_x - br_x;
        s1_sim_d = ai_x - bi_x;
      end
      MODE_NEG: begin
        s1_sre_d = -ar_x;
        s1_sim_d = -ai_x;
      end
      default: begin
        s1_sre_d = '0;
        s1_sim_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (s1_rdy && s0_vld_q) begin
      s1_mode_q <= s0_mode_q;
      s1_prr_q  <= s0_ar_q * s0_br_q;
      s1_pii_q  <= s0_ai_q * s0_bi_q;
      s1_pri_q  <= s0_ar_q * s0_bi_q;
      s1_pir_q  <= s0_ai_q * s0_br_q;
      s1_drr_q  <= s0_br_q * s0_br_q;
      s1_dii_q  <= s0_bi_q * s0_bi_q;
      s1_sre_q  <= s1_sre_d;
      s1_sim_q  <= s1_sim_d;
    end
  end

  // Stage 2: exact signed results before scaling, and the squared divisor.
  assign s2_den_d = $unsigned(s1_drr_q) + $unsigned(s1_dii_q);

  always_comb begin
    case (s1_mode_q)
      MODE_ADD, MODE_SUB, MODE_NEG: begin
        s2_vre_d = VW'(s1_sre_q);
        s2_vim_d = VW'(s1_sim_q);
      end
      MODE_MUL: begin
        s2_vre_d = VW'(s1_prr_q) - VW'(s1_pii_q);
        s2_vim_d = VW'(s1_pri_q) + VW'(s1_pir_q);
      end
      MODE_DIV: begin
        s2_vre_d = VW'(s1_prr_q) + VW'(s1_pii_q);
        s2_vim_d = VW'(s1_pir_q) - VW'(s1_pri_q);
      end
      default: begin
        s2_vre_d = '0;
        s2_vim_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (s2_rdy && s1_vld_q) begin
      s2_mode_q <= s1_mode_q;
      s2_den_q  <= s2_den_d;
      s2_dz_q   <= (s1_mode_q == MODE_DIV) && (s2_den_d == '0);
      s2_vre_q  <= s2_vre_d;
      s2_vim_q  <= s2_vim_d;
    end
  end

  // Stage 3: sign and magnitude; products drop their fraction, dividends gain one.
  assign is_mul = (s2_mode_q == MODE_MUL);
  assign is_div = (s2_mode_q == MODE_DIV) && !s2_dz_q;
  assign mag_re = s2_vre_q[VW-1] ? $unsigned(-s2_vre_q) : $unsigned(s2_vre_q);
  assign mag_im = s2_vim_q[VW-1] ? $unsigned(-s2_vim_q) : $unsigned(s2_vim_q);

  always_ff @(posedge clk_i) begin
    if (s3_rdy && s2_vld_q) begin
      s3_ctl_q.neg_re <= s2_vre_q[VW-1] && !s2_dz_q;
      s3_ctl_q.neg_im <= s2_vim_q[VW-1] && !s2_dz_q;
      s3_ctl_q.div    <= is_div;
      s3_ctl_q.dz     <= s2_dz_q;
      s3_ctl_q.ovf_re <= 1'b0;
      s3_ctl_q.ovf_im <= 1'b0;
      s3_den_q        <= s2_den_q;
      if (s2_dz_q) begin
        s3_rre_q <= '0;
        s3_rim_q <= '0;
      end else if (is_mul) begin
        s3_rre_q <= RW'(mag_re >> FRAC_BITS);
        s3_rim_q <= RW'(mag_im >> FRAC_BITS);
      end else if (is_div) begin
        s3_rre_q <= RW'(mag_re) << FRAC_BITS;
        s3_rim_q <= RW'(mag_im) << FRAC_BITS;
      end else begin
        s3_rre_q <= RW'(mag_re);
        s3_rim_q <= RW'(mag_im);
      end
    end
  end

  // Stage 4: a quotient that needs more than DATA_WIDTH bits saturates in any case.
  assign den_top = RW'(s3_den_q) << W;

  always_ff @(posedge clk_i) begin
    if (s4_rdy && s3_vld_q) begin
      s4_ctl_q.neg_re <= s3_ctl_q.neg_re;
      s4_ctl_q.neg_im <= s3_ctl_q.neg_im;
      s4_ctl_q.div    <= s3_ctl_q.div;
      s4_ctl_q.dz     <= s3_ctl_q.dz;
      s4_ctl_q.ovf_re <= s3_ctl_q.div && (s3_rre_q >= den_top);
      s4_ctl_q.ovf_im <= s3_ctl_q.div && (s3_rim_q >= den_top);
      s4_den_q        <= s3_den_q;
      s4_rre_q        <= s3_rre_q;
      s4_rim_q        <= s3_rim_q;
    end
  end

  assign dv[0]   = s4_vld_q;
  assign dctl[0] = s4_ctl_q;
  assign dden[0] = s4_den_q;
  assign dre[0]  = s4_rre_q;
  assign dim[0]  = s4_rim_q;
  assign dqre[0] = '0;
  assign dqim[0] = '0;
  assign drdy[W] = out_rdy;

  for (genvar j = 0; j < W; j++) begin : g_div
    cfpa_div_stage #(
      .DATA_W (W),
      .REM_W  (RW),
      .BIT    (W - 1 - j)
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (dv[j]),
      .ready_o (drdy[j]),
      .ctl_i   (dctl[j]),
      .den_i   (dden[j]),
      .r_re_i  (dre[j]),
      .r_im_i  (dim[j]),
      .q_re_i  (dqre[j]),
      .q_im_i  (dqim[j]),
      .valid_o (dv[j+1]),
      .ready_i (drdy[j+1]),
      .ctl_o   (dctl[j+1]),
      .den_o   (dden[j+1]),
      .r_re_o  (dre[j+1]),
      .r_im_o  (dim[j+1]),
      .q_re_o  (dqre[j+1]),
      .q_im_o  (dqim[j+1])
    );
  end

  // Output stage: pick the magnitude, saturate and encode.
  assign lim_neg = VW'(1) << (W - 1);
  assign lim_pos = lim_neg - VW'(1);

  always_comb begin
    if (dctl[W].div) begin
      fm_re = dctl[W].ovf_re ? VW'({W{1'b1}}) : VW'(dqre[W]);
      fm_im = dctl[W].ovf_im ? VW'({W{1'b1}}) : VW'(dqim[W]);
    end else begin
      fm_re = dre[W][VW-1:0];
      fm_im = dim[W][VW-1:0];
    end
    sat_re = dctl[W].neg_re ? (fm_re > lim_neg) : (fm_re > lim_pos);
    sat_im = dctl[W].neg_im ? (fm_im > lim_neg) : (fm_im > lim_pos);
    if (sat_re) begin
      fv_re = dctl[W].neg_re ? lim_neg[W-1:0] : lim_pos[W-1:0];
    end else begin
      fv_re = dctl[W].neg_re ? (~fm_re[W-1:0] + W'(1)) : fm_re[W-1:0];
    end
    if (sat_im) begin
      fv_im = dctl[W].neg_im ? lim_neg[W-1:0] : lim_pos[W-1:0];
    end else begin
      fv_im = dctl[W].neg_im ? (~fm_im[W-1:0] + W'(1)) : fm_im[W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy && dv[W]) begin
      out_re_q <= FIELD_W'($signed(fv_re));
      out_im_q <= FIELD_W'($signed(fv_im));
      if (dctl[W].dz) begin
        out_st_q <= STATUS_DIV0;
      end else if (sat_re || sat_im) begin
        out_st_q <= STATUS_SAT;
      end else begin
        out_st_q <= STATUS_OK;
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_im_q, out_re_q};
  assign m_axis_tuser  = out_st_q;

endmodule

// ===== tb/tb_complex_fixed_point_alu_unit.sv =====
// Stream testbench for the complex fixed-point ALU with a self-checking scoreboard.
`timescale 1ns / 100ps

module tb_complex_fixed_point_alu_unit;
  import cfpa_pkg::*;

  localparam int DW          = 32;
  localparam int FB          = 16;
  localparam int N_RANDOM    = 1330;
  localparam int DRAIN_WAIT  = DW + 40;
  localparam int STALL_MAX   = 4000;
  localparam int QUIET_START = 300;
  localparam int QUIET_END   = 700;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] a_re;
    logic [31:0] a_im;
    logic [31:0] b_re;
    logic [31:0] b_im;
  } alu_req_t;

  typedef struct packed {
    logic [31:0] res_re;
    logic [31:0] res_im;
    logic [1:0]  status;
  } alu_res_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     s_axis_tvalid;
  logic                     s_axis_tready;
  logic [4*FIELD_W-1:0]     s_axis_tdata;
  logic [2:0]               s_axis_tuser;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready;
  logic [2*FIELD_W-1:0]     m_axis_tdata;
  logic [1:0]               m_axis_tuser;

  alu_req_t pending_reqs[$];
  alu_res_t expected_results[$];
  alu_req_t cur_req;
  logic     req_taken;
  int       cycle_cnt;
  int       stall_cnt;
  int       fail_cnt;

  complex_fixed_point_alu_unit #(
    .DATA_WIDTH(DW),
    .FRAC_BITS (FB)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Clip an exact value to the signed result range and flag clipping.
  function automatic logic [31:0] clip_part(input logic signed [127:0] v, inout logic clipped);
    logic signed [127:0] hi;
    logic signed [127:0] lo;
    hi = 128'sd2147483647;
    lo = -128'sd2147483648;
    if (v > hi) begin
      clipped = 1'b1;
      return hi[31:0];
    end
    if (v < lo) begin
      clipped = 1'b1;
      return lo[31:0];
    end
    return v[31:0];
  endfunction

  // Exact complex arithmetic, truncated toward zero, then saturated.
  function automatic alu_res_t complex_result(input alu_req_t r);
    logic signed [127:0] ar, ai, br, bi, pr, pi, den;
    logic                clipped;
    alu_res_t            res;
    ar = 128'(signed'(r.a_re));
    ai = 128'(signed'(r.a_im));
    br = 128'(signed'(r.b_re));
    bi = 128'(signed'(r.b_im));
    pr = '0;
    pi = '0;
    clipped = 1'b0;
    res.status = STATUS_OK;
    case (r.mode)
      MODE_ADD: begin
        pr = ar + br;
        pi = ai + bi;
      end
      MODE_SUB: begin
        pr = ar - br;
        pi = ai - bi;
      end
      MODE_MUL: begin
        pr = (ar * br - ai * bi) / (128'sd1 <<< FB);
        pi = (ar * bi + ai * br) / (128'sd1 <<< FB);
      end
      MODE_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          res.status = STATUS_DIV0;
        end else begin
          pr = ((ar * br + ai * bi) * (128'sd1 <<< FB)) / den;
          pi = ((ai * br - ar * bi) * (128'sd1 <<< FB)) / den;
        end
      end
      MODE_NEG: begin
        pr = -ar;
        pi = -ai;
      end
      default: ;
    endcase
    res.res_re = clip_part(pr, clipped);
    res.res_im = clip_part(pi, clipped);
    if (res.status == STATUS_OK && clipped) res.status = STATUS_SAT;
    return res;
  endfunction

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'(signed'($urandom_range(0, 8)) - 4);
      3, 4:    return 32'(signed'($urandom_range(0, 32'h7ffff)) - 32'sh40000);
      5:       return 32'(signed'($urandom_range(0, 32'h7ff)) - 32'sh400) <<< FB;
      default: return $urandom();
    endcase
  endfunction

  task automatic queue_req(input logic [2:0] mode, input logic [31:0] a_re, a_im, b_re, b_im);
    alu_req_t r;
    r.mode = mode;
    r.a_re = a_re;
    r.a_im = a_im;
    r.b_re = b_re;
    r.b_im = b_im;
    pending_reqs.push_back(r);
  endtask

  // Request driver: a held request stays until it is taken. Both sides run without
  // idling through one stretch of cycles.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= (cycle_cnt >= QUIET_START && cycle_cnt < QUIET_END) ||
                       ($urandom_range(0, 99) >= 7);
      if (!s_axis_tvalid || req_taken) begin
        if (pending_reqs.size() != 0 &&
            ((cycle_cnt >= QUIET_START && cycle_cnt < QUIET_END) ||
             $urandom_range(0, 99) >= 7)) begin
          cur_req = pending_reqs.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {cur_req.b_im, cur_req.b_re, cur_req.a_im, cur_req.a_re};
          s_axis_tuser  <= cur_req.mode;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: predict on each taken request, check on each delivered result.
  always @(posedge clk_i) begin
    alu_req_t r;
    alu_res_t want;
    logic     took_in;
    logic     took_out;
    int       errs;
    if (!rst_ni) begin
      req_taken <= 1'b0;
      cycle_cnt <= 0;
      stall_cnt <= 0;
      fail_cnt  <= 0;
    end else begin
      took_in  = s_axis_tvalid && s_axis_tready;
      took_out = m_axis_tvalid && m_axis_tready;
      errs     = 0;
      req_taken <= took_in;
      cycle_cnt <= cycle_cnt + 1;
      stall_cnt <= (took_in || took_out) ? 0 : stall_cnt + 1;
      if (took_in) begin
        r.mode = s_axis_tuser;
        {r.b_im, r.b_re, r.a_im, r.a_re} = s_axis_tdata;
        expected_results.push_back(complex_result(r));
      end
      if (took_out) begin
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding");
          errs++;
        end else begin
          want = expected_results.pop_front();
          if (m_axis_tdata[31:0] !== want.res_re) begin
            $error("res_re: expected %h, got %h", want.res_re, m_axis_tdata[31:0]);
            errs++;
          end
          if (m_axis_tdata[63:32] !== want.res_im) begin
            $error("res_im: expected %h, got %h", want.res_im, m_axis_tdata[63:32]);
            errs++;
          end
          if (m_axis_tuser !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
            errs++;
          end
        end
      end
      fail_cnt <= fail_cnt + errs;
      if (stall_cnt >= STALL_MAX) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    logic [2:0] mode;
    rst_ni = 1'b0;

    // Extremes of every operation, zero divisor, negating the most negative value,
    // and the unused modes.
    queue_req(MODE_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    queue_req(MODE_ADD, 32'h0001_0000, 32'hffff_0000, 32'h0002_8000, 32'h0000_0001);
    queue_req(MODE_SUB, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
    queue_req(MODE_SUB, 32'h0003_0000, 32'h0000_0000, 32'h0001_0000, 32'h0000_0000);
    queue_req(MODE_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    queue_req(MODE_MUL, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
    queue_req(MODE_MUL, 32'h0002_0000, 32'h0003_0000, 32'hffff_0000, 32'h0000_8000);
    queue_req(MODE_MUL, 32'hffff_ffff, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
    queue_req(MODE_DIV, 32'h0001_0000, 32'h0002_0000, 32'h0000_0000, 32'h0000_0000);
    queue_req(MODE_DIV, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000);
    queue_req(MODE_DIV, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 32'h0000_0000);
    queue_req(MODE_DIV, 32'h0004_0000, 32'h0002_0000, 32'h0002_0000, 32'hffff_0000);
    queue_req(MODE_DIV, 32'hffff_ffff, 32'h0000_0003, 32'h8000_0000, 32'h7fff_ffff);
    queue_req(MODE_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    queue_req(MODE_NEG, 32'h8000_0000, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000);
    queue_req(MODE_NEG, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff, 32'hffff_ffff);
    queue_req(MODE_NEG, 32'h0001_2345, 32'hfffe_0000, 32'h1234_5678, 32'h8765_4321);
    queue_req(3'd5, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h0000_0001);
    queue_req(3'd6, 32'h1234_5678, 32'h0, 32'h0, 32'h0);
    queue_req(3'd7, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);

    for (int i = 0; i < N_RANDOM; i++) begin
      mode = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      queue_req(mode, pick_operand(), pick_operand(), pick_operand(), pick_operand());
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (pending_reqs.size() == 0 && !s_axis_tvalid);
    wait (expected_results.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (fail_cnt == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
